/* hdl/bfrp_pkg.sv */
package bfrp_pkg;

  localparam int unsigned SIZE_BITS = 16;
  localparam int unsigned ADDR_BITS = 20;
  localparam int unsigned TAG_W     = 4;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned TOT_W     = 20;
  localparam int unsigned USERS_W   = 8;

  localparam logic [USERS_W-1:0] USERS_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT  = 2'd0,
    MODE_ALLOC   = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_ZERO     = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_NO_FIT   = 3'd3,
    STAT_BAD_TAG  = 3'd4,
    STAT_OVER_REL = 3'd5,
    STAT_ADDR_OVF = 3'd6
  } status_e;

  // One region table entry, as stored in the RAM.
  typedef struct packed {
    logic [USERS_W-1:0]   users;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] free_amt;
    logic [SIZE_BITS-1:0] cap;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Per-item result, totals are added on the way out.
  typedef struct packed {
    status_e              status;
    logic [TAG_W-1:0]     tag;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] free_amt;
  } result_t;

endpackage

/* hdl/bfrp_ram.sv */
module bfrp_ram #(
  parameter int unsigned WIDTH = 60,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/best_fit_region_pool_top.sv */
// Flow: insert, unused mode and early errors go from idle straight to S_DONE; release reads
//   the entry and updates it in S_REL; allocate does one RAM read per region in S_SCAN, then
//   writes back in S_WB, or goes straight to S_DONE when the sweep finds no fit. S_DONE waits
//   while the result register stays full. Throughput: one item at a time; the next transfer
//   is taken once the result register has been loaded.
// Reset: rst_ni asynchronous, active low; clears the table count, next address, totals and
//   handshake state. Table RAM contents are not cleared; only entries below the count are read.
module best_fit_region_pool_top #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: pool_base
  input  logic                               cfg_we_i,
  input  logic [bfrp_pkg::ADDR_BITS-1:0]     cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,   // amount[15:0], region_tag[19:16]
  input  logic [bfrp_pkg::MODE_W-1:0]        s_axis_tuser,   // mode
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [79:0]                        m_axis_tdata,   // tag_out[3:0], address_out[23:4],
                                                             // region_free[39:24],
                                                             // total_free[59:40],
                                                             // total_used[79:60]
  output logic [bfrp_pkg::STATUS_W-1:0]      m_axis_tuser    // status
);

  import bfrp_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CMP_W  = (CNT_W > TAG_W) ? CNT_W : TAG_W;
  localparam int unsigned NA_W   = ADDR_BITS + 1;           // next address, reaches 2^ADDR_BITS
  localparam int unsigned OVF_W  = ADDR_BITS + 2;
  // Exact running sums, one bit wider than the reported total at least.
  localparam int unsigned SUM_W  = ((SIZE_BITS + CNT_W) > TOT_W) ? (SIZE_BITS + CNT_W)
                                                                 : (TOT_W + 1);
  localparam logic [OVF_W-1:0] ADDR_SPAN = OVF_W'(1) << ADDR_BITS;

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;   // best-fit sweep, one entry per cycle
  localparam logic [2:0] S_WB   = 3'd2;   // write back chosen region
  localparam logic [2:0] S_REL  = 3'd3;   // release: entry read returns
  localparam logic [2:0] S_DONE = 3'd4;   // hand result to output register

  // Input field unpack
  logic [SIZE_BITS-1:0] in_amount;
  logic [TAG_W-1:0]     in_tag;
  mode_e                in_mode;

  assign in_amount = s_axis_tdata[15:0];
  assign in_tag    = s_axis_tdata[19:16];
  assign in_mode   = mode_e'(s_axis_tuser);

  // Control state
  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [NA_W-1:0]      next_q, next_d;
  logic [SUM_W-1:0]     free_sum_q, free_sum_d;
  logic [SUM_W-1:0]     cap_sum_q, cap_sum_d;
  logic                 m_valid_q, m_valid_d;
  logic                 found_q, found_d;

  // Working registers
  logic [SIZE_BITS-1:0] amount_q, amount_d;
  logic [TAG_W-1:0]     tag_q, tag_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;      // next entry to read
  logic [CNT_W-1:0]     cmp_idx_q, cmp_idx_d;    // entry whose data is on the RAM output
  logic [SIZE_BITS-1:0] best_diff_q, best_diff_d;
  logic [IDX_W-1:0]     best_idx_q, best_idx_d;
  entry_t               best_q, best_d;
  result_t              res_q, res_d;
  logic [79:0]          m_data_q, m_data_d;
  logic [STATUS_W-1:0]  m_user_q, m_user_d;

  // Table RAM
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  entry_t               ram_wdata, ram_rdata;
  logic [ENTRY_W-1:0]   ram_rdata_raw;

  bfrp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  // Totals as reported: saturate the exact sums.
  logic [SUM_W-1:0]     used_sum;
  logic [TOT_W-1:0]     tot_free, tot_used;

  assign used_sum = cap_sum_q - free_sum_q;
  assign tot_free = (|free_sum_q[SUM_W-1:TOT_W]) ? '1 : free_sum_q[TOT_W-1:0];
  assign tot_used = (|used_sum[SUM_W-1:TOT_W])   ? '1 : used_sum[TOT_W-1:0];

  assign s_axis_tready = (state_q == S_IDLE);

  // Scratch values
  logic [SIZE_BITS-1:0] diff;
  logic [SIZE_BITS:0]   rel_sum;
  entry_t               upd;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    next_d      = next_q;
    free_sum_d  = free_sum_q;
    cap_sum_d   = cap_sum_q;
    m_valid_d   = m_valid_q;
    found_d     = found_q;
    amount_d    = amount_q;
    tag_d       = tag_q;
    rd_idx_d    = rd_idx_q;
    cmp_idx_d   = cmp_idx_q;
    best_diff_d = best_diff_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    res_d       = res_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    diff        = '0;
    rel_sum     = '0;
    upd         = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    // pool_base only matters while the table is empty
    if (cfg_we_i && (count_q == '0)) begin
      next_d = NA_W'(cfg_wdata_i);
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          amount_d = in_amount;
          tag_d    = in_tag;
          res_d    = '0;
          state_d  = S_DONE;
          unique case (in_mode)
            MODE_INSERT: begin
              priority if (in_amount == '0) begin
                res_d.status = STAT_ZERO;
              end else if (count_q == CNT_W'(MAX_REGIONS)) begin
                res_d.status = STAT_FULL;
              end else if ((OVF_W'(next_q) + OVF_W'(in_amount)) > ADDR_SPAN) begin
                res_d.status = STAT_ADDR_OVF;
              end else begin
                // append new region at the table tail
                ram_we             = 1'b1;
                ram_waddr          = count_q[IDX_W-1:0];
                ram_wdata.users    = '0;
                ram_wdata.addr     = next_q[ADDR_BITS-1:0];
                ram_wdata.free_amt = in_amount;
                ram_wdata.cap      = in_amount;
                next_d             = next_q + NA_W'(in_amount);
                count_d            = count_q + CNT_W'(1);
                free_sum_d         = free_sum_q + SUM_W'(in_amount);
                cap_sum_d          = cap_sum_q + SUM_W'(in_amount);
                res_d.tag          = TAG_W'(count_q);
                res_d.addr         = next_q[ADDR_BITS-1:0];
                res_d.free_amt     = in_amount;
              end
            end
            MODE_ALLOC: begin
              priority if (in_amount == '0) begin
                res_d.status = STAT_ZERO;
              end else if (count_q == '0) begin
                res_d.status = STAT_NO_FIT;
              end else begin
                // start the sweep at entry 0
                ram_re    = 1'b1;
                ram_raddr = '0;
                rd_idx_d  = CNT_W'(1);
                cmp_idx_d = '0;
                found_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            MODE_RELEASE: begin
              if (CMP_W'(in_tag) >= CMP_W'(count_q)) begin
                res_d.status = STAT_BAD_TAG;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = IDX_W'(in_tag);
                state_d   = S_REL;
              end
            end
            MODE_NONE: begin
              res_d = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        // strict less-than keeps the earliest region on ties
        if (ram_rdata.free_amt >= amount_q) begin
          diff = ram_rdata.free_amt - amount_q;
          if (!found_q || (diff < best_diff_q)) begin
            found_d     = 1'b1;
            best_diff_d = diff;
            best_idx_d  = cmp_idx_q[IDX_W-1:0];
            best_d      = ram_rdata;
          end
        end
        if (rd_idx_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + CNT_W'(1);
        end
        cmp_idx_d = cmp_idx_q + CNT_W'(1);
        if (cmp_idx_q == (count_q - CNT_W'(1))) begin
          if (found_d) begin
            state_d = S_WB;
          end else begin
            res_d        = '0;
            res_d.status = STAT_NO_FIT;
            state_d      = S_DONE;
          end
        end
      end

      S_WB: begin
        upd          = best_q;
        upd.addr     = best_q.addr + ADDR_BITS'(amount_q);
        upd.free_amt = best_q.free_amt - amount_q;
        if (best_q.users != USERS_MAX) begin
          upd.users = best_q.users + USERS_W'(1);
        end
        ram_we         = 1'b1;
        ram_waddr      = best_idx_q;
        ram_wdata      = upd;
        free_sum_d     = free_sum_q - SUM_W'(amount_q);
        res_d.status   = STAT_OK;
        res_d.tag      = TAG_W'(best_idx_q);
        res_d.addr     = best_q.addr;
        res_d.free_amt = upd.free_amt;
        state_d        = S_DONE;
      end

      S_REL: begin
        rel_sum = {1'b0, ram_rdata.free_amt} + {1'b0, amount_q};
        res_d.tag  = tag_q;
        res_d.addr = '0;
        if (rel_sum > {1'b0, ram_rdata.cap}) begin
          // refused: report the unchanged free amount
          res_d.status   = STAT_OVER_REL;
          res_d.free_amt = ram_rdata.free_amt;
        end else begin
          upd          = ram_rdata;
          upd.free_amt = rel_sum[SIZE_BITS-1:0];
          if (ram_rdata.users != '0) begin
            upd.users = ram_rdata.users - USERS_W'(1);
          end
          ram_we         = 1'b1;
          ram_waddr      = IDX_W'(tag_q);
          ram_wdata      = upd;
          free_sum_d     = free_sum_q + SUM_W'(amount_q);
          res_d.status   = STAT_OK;
          res_d.free_amt = upd.free_amt;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // totals already reflect this item
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = res_q.status;
          m_data_d  = {tot_used, tot_free, res_q.free_amt, res_q.addr, res_q.tag};
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      next_q     <= '0;
      free_sum_q <= '0;
      cap_sum_q  <= '0;
      m_valid_q  <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      next_q     <= next_d;
      free_sum_q <= free_sum_d;
      cap_sum_q  <= cap_sum_d;
      m_valid_q  <= m_valid_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    amount_q    <= amount_d;
    tag_q       <= tag_d;
    rd_idx_q    <= rd_idx_d;
    cmp_idx_q   <= cmp_idx_d;
    best_diff_q <= best_diff_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    res_q       <= res_d;
    m_data_q    <= m_data_d;
    m_user_q    <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

/* dv/region_pool_checker.sv */
module region_pool_checker #(
  parameter int unsigned MAX_REGIONS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bfrp_pkg::ADDR_BITS-1:0] cfg_wdata_i,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  logic [23:0]                    req_data_i,   // amount[15:0], region_tag[19:16]
  input  logic [bfrp_pkg::MODE_W-1:0]    req_user_i,   // mode
  input  logic                           rsp_valid_i,
  input  logic                           rsp_ready_i,
  input  logic [79:0]                    rsp_data_i,   // tag, address, region_free,
                                                       // total_free, total_used
  input  logic [bfrp_pkg::STATUS_W-1:0]  rsp_user_i,   // status
  output int unsigned                    pending_o,
  output int unsigned                    mismatch_count_o
);

  import bfrp_pkg::*;

  localparam int unsigned ADDR_SPAN = 1 << ADDR_BITS;
  localparam int unsigned TOT_MAX   = (1 << TOT_W) - 1;

  typedef struct packed {
    status_e              status;
    logic [TAG_W-1:0]     tag;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] region_free;
    logic [TOT_W-1:0]     total_free;
    logic [TOT_W-1:0]     total_used;
  } reply_t;

  // shadow of the region table
  logic [SIZE_BITS-1:0] cap_q   [MAX_REGIONS];
  logic [SIZE_BITS-1:0] free_q  [MAX_REGIONS];
  logic [ADDR_BITS-1:0] addr_q  [MAX_REGIONS];
  logic [USERS_W-1:0]   users_q [MAX_REGIONS];
  int unsigned          count_q;
  int unsigned          next_addr_q;
  logic [ADDR_BITS-1:0] base_q;

  reply_t      expected_replies[$];
  int unsigned mismatches;

  // totals are recomputed from the table; on errors the table is untouched
  function automatic reply_t make_reply(input status_e st, input logic [TAG_W-1:0] tag,
                                        input logic [ADDR_BITS-1:0] a,
                                        input logic [SIZE_BITS-1:0] fr);
    int unsigned f;
    int unsigned u;
    reply_t      r;
    f = 0;
    u = 0;
    for (int i = 0; i < int'(count_q); i++) begin
      f += 32'(free_q[i]);
      u += 32'(cap_q[i]) - 32'(free_q[i]);
    end
    r.status      = st;
    r.tag         = tag;
    r.addr        = a;
    r.region_free = fr;
    r.total_free  = (f > TOT_MAX) ? TOT_W'(TOT_MAX) : TOT_W'(f);
    r.total_used  = (u > TOT_MAX) ? TOT_W'(TOT_MAX) : TOT_W'(u);
    return r;
  endfunction

  function automatic reply_t apply_request(input mode_e m, input logic [SIZE_BITS-1:0] amt,
                                           input logic [TAG_W-1:0] tag);
    int unsigned          slot;
    int unsigned          best_gap;
    bit                   found;
    logic [ADDR_BITS-1:0] start;
    found    = 1'b0;
    slot     = 0;
    best_gap = 0;
    case (m)
      MODE_INSERT: begin
        if (amt == '0) return make_reply(STAT_ZERO, '0, '0, '0);
        if (count_q >= MAX_REGIONS) return make_reply(STAT_FULL, '0, '0, '0);
        if (next_addr_q + 32'(amt) > ADDR_SPAN) return make_reply(STAT_ADDR_OVF, '0, '0, '0);
        slot          = count_q;
        cap_q[slot]   = amt;
        free_q[slot]  = amt;
        addr_q[slot]  = ADDR_BITS'(next_addr_q);
        users_q[slot] = '0;
        next_addr_q  += 32'(amt);
        count_q++;
        return make_reply(STAT_OK, TAG_W'(slot), addr_q[slot], amt);
      end
      MODE_ALLOC: begin
        if (amt == '0) return make_reply(STAT_ZERO, '0, '0, '0);
        // smallest leftover wins, earliest on ties
        for (int i = 0; i < int'(count_q); i++) begin
          if (free_q[i] >= amt && (!found || 32'(free_q[i]) - 32'(amt) < best_gap)) begin
            found    = 1'b1;
            best_gap = 32'(free_q[i]) - 32'(amt);
            slot     = 32'(i);
          end
        end
        if (!found) return make_reply(STAT_NO_FIT, '0, '0, '0);
        start        = addr_q[slot];
        addr_q[slot] = start + ADDR_BITS'(amt);
        free_q[slot] = free_q[slot] - amt;
        if (users_q[slot] != USERS_MAX) users_q[slot]++;
        return make_reply(STAT_OK, TAG_W'(slot), start, free_q[slot]);
      end
      MODE_RELEASE: begin
        if (32'(tag) >= count_q) return make_reply(STAT_BAD_TAG, '0, '0, '0);
        if (int'(free_q[tag]) + int'(amt) > int'(cap_q[tag]))
          return make_reply(STAT_OVER_REL, tag, '0, free_q[tag]);
        free_q[tag] = free_q[tag] + amt;
        if (users_q[tag] != '0) users_q[tag]--;
        return make_reply(STAT_OK, tag, '0, free_q[tag]);
      end
      default: return make_reply(STAT_OK, '0, '0, '0);
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    reply_t got;
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_REGIONS); i++) begin
        cap_q[i]   = '0;
        free_q[i]  = '0;
        addr_q[i]  = '0;
        users_q[i] = '0;
      end
      count_q     = 0;
      next_addr_q = 0;
      base_q      = '0;
      mismatches  = 0;
      expected_replies.delete();
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (rsp_valid_i && rsp_ready_i) begin
        got.status      = status_e'(rsp_user_i);
        got.tag         = rsp_data_i[3:0];
        got.addr        = rsp_data_i[23:4];
        got.region_free = rsp_data_i[39:24];
        got.total_free  = rsp_data_i[59:40];
        got.total_used  = rsp_data_i[79:60];
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result st=%0d tag=%0d addr=%h", $realtime,
                     got.status, got.tag, got.addr);
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status || got.tag !== want.tag ||
              got.addr !== want.addr || got.region_free !== want.region_free ||
              got.total_free !== want.total_free || got.total_used !== want.total_used) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp st=%0d tag=%0d addr=%h free=%h tf=%h tu=%h",
                       $realtime, want.status, want.tag, want.addr, want.region_free,
                       want.total_free, want.total_used);
              $display("%0t:          got st=%0d tag=%0d addr=%h free=%h tf=%h tu=%h",
                       $realtime, got.status, got.tag, got.addr, got.region_free,
                       got.total_free, got.total_used);
            end
          end
        end
      end
      if (cfg_we_i) begin
        base_q = cfg_wdata_i;
        if (count_q == 0) next_addr_q = 32'(base_q);
      end
      if (req_valid_i && req_ready_i)
        expected_replies.push_back(apply_request(mode_e'(req_user_i), req_data_i[15:0],
                                                 req_data_i[19:16]));
    end
    pending_o        <= expected_replies.size();
    mismatch_count_o <= mismatches;
  end

endmodule

/* dv/tb_top.sv */
module tb_top;
  import bfrp_pkg::*;

  // Stimulus changes on the falling edge, the DUT and checker sample on the rising edge.
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [ADDR_BITS-1:0] cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata;   // amount[15:0], region_tag[19:16], zero fill
  logic [MODE_W-1:0]    s_axis_tuser;   // mode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [79:0]          m_axis_tdata;   // tag_out, address_out, region_free, totals
  logic [STATUS_W-1:0]  m_axis_tuser;   // status

  int unsigned pending;
  int unsigned mismatch_count;
  int unsigned burst_left;
  logic [5:0]  stall_step = '0;
  logic [31:0] stall_pat  = '1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  best_fit_region_pool_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  region_pool_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_valid_i      (s_axis_tvalid),
    .req_ready_i      (s_axis_tready),
    .req_data_i       (s_axis_tdata),
    .req_user_i       (s_axis_tuser),
    .rsp_valid_i      (m_axis_tvalid),
    .rsp_ready_i      (m_axis_tready),
    .rsp_data_i       (m_axis_tdata),
    .rsp_user_i       (m_axis_tuser),
    .pending_o        (pending),
    .mismatch_count_o (mismatch_count)
  );

  // Result side backpressure: a new 32-bit ready pattern is drawn each time the 6-bit step counter wraps.
  // A quarter of the windows never stall, some are sparse (AND of two draws).
  always @(negedge clk_i) begin : result_stall
    int unsigned pick;
    if (stall_step == '0) begin
      pick = $urandom_range(0, 7);
      if (pick < 2)       stall_pat = '1;
      else if (pick == 2) stall_pat = $urandom & $urandom;
      else                stall_pat = $urandom;
    end
    m_axis_tready <= stall_pat[stall_step[4:0]];
    stall_step     = stall_step + 6'd1;
  end

  // After each transfer: count down the burst; at its end, drop tvalid for a random gap.
  // Some bursts are followed by no gap at all, so tvalid stays high across them.
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // One request transfer; tvalid is left high so the next item can follow back to back.
  task automatic send_item(input mode_e m, input logic [SIZE_BITS-1:0] amt,
                           input logic [TAG_W-1:0] tag);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = m;
    s_axis_tdata  = {4'h0, tag, amt};
    do @(posedge clk_i); while (!s_axis_tready);
    pace();
  endtask

  // Hold off until every predicted result has been seen, plus a little margin.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_pool_base(input logic [ADDR_BITS-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  initial begin : stimulus
    mode_e                m;
    logic [SIZE_BITS-1:0] amt;
    logic [TAG_W-1:0]     tag;
    int unsigned          pick;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_NONE;
    burst_left    = 4;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty table, base at the very top: every error path that needs no region.
    write_pool_base(20'hFFFFF);
    send_item(MODE_INSERT, 16'h0000, 4'h0);     // zero size
    send_item(MODE_INSERT, 16'h0002, 4'h0);     // would run past the address space
    send_item(MODE_ALLOC, 16'h0005, 4'h0);      // nothing to fit into
    send_item(MODE_ALLOC, 16'h0000, 4'h0);      // zero request
    send_item(MODE_RELEASE, 16'h0000, 4'h0);    // no region 0 yet
    send_item(MODE_NONE, 16'hFFFF, 4'hF);       // unused mode, all ones
    wait_idle();

    // Base low extreme, then a high base so large regions overflow later on.
    write_pool_base(20'h00000);
    write_pool_base(20'hC0000);
    send_item(MODE_INSERT, 16'hFFFF, 4'h0);     // biggest region
    send_item(MODE_INSERT, 16'h0001, 4'h0);
    send_item(MODE_INSERT, 16'h0100, 4'h0);
    send_item(MODE_INSERT, 16'h0100, 4'h0);
    send_item(MODE_ALLOC, 16'h0100, 4'h0);      // exact fit tie: earliest region
    send_item(MODE_ALLOC, 16'h0100, 4'h0);      // next exact fit
    send_item(MODE_ALLOC, 16'h0001, 4'h0);      // one-unit region is exact
    send_item(MODE_ALLOC, 16'h0001, 4'h0);      // only the big region is left
    send_item(MODE_ALLOC, 16'hFFFF, 4'h0);      // no longer fits
    send_item(MODE_RELEASE, 16'h0002, 4'h1);    // over release
    send_item(MODE_RELEASE, 16'h0001, 4'h1);
    send_item(MODE_RELEASE, 16'h0000, 4'h2);    // zero release is legal
    send_item(MODE_RELEASE, 16'h0000, 4'h2);    // user count already at zero
    send_item(MODE_RELEASE, 16'h0005, 4'hF);    // tag beyond the table
    wait_idle();

    // Random traffic; the table fills early, then mostly alloc/release churn.
    for (int n = 0; n < 500; n++) begin
      if (n == 250) begin
        // pause with nothing in flight; base write on a non-empty table has no effect
        wait_idle();
        write_pool_base(ADDR_BITS'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 15)      m = MODE_INSERT;
      else if (pick < 60) m = MODE_ALLOC;
      else if (pick < 95) m = MODE_RELEASE;
      else                m = MODE_NONE;
      case ($urandom_range(0, 7))
        0: amt = SIZE_BITS'($urandom);
        1: begin
          case ($urandom_range(0, 2))
            0:       amt = 16'h0000;
            1:       amt = 16'h0001;
            default: amt = 16'hFFFF;
          endcase
        end
        2, 3:    amt = SIZE_BITS'($urandom_range(1, 4096));
        default: amt = SIZE_BITS'($urandom_range(0, 256));
      endcase
      tag = TAG_W'($urandom_range(0, 15));
      send_item(m, amt, tag);
    end

    // Drain: all results in, then a margin longer than the slowest allocate.
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
